// ----- sv/vlmr_pkg.sv -----
// Shared types and constants of the variable-length message ring.
package vlmr_pkg;
	localparam int HEADER_BYTES = 4;

	typedef enum logic [2:0] {
		OP_RESERVE = 3'd0,
		OP_WRITE   = 3'd1,
		OP_COMMIT  = 3'd2,
		OP_PEEK    = 3'd3,
		OP_READ    = 3'd4,
		OP_RELEASE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOSPC = 2'd1,
		ST_EMPTY = 2'd2,
		ST_SEQ   = 2'd3
	} status_t;

	// one request as queued between front and back
	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] msg_len;
		logic [7:0]  data_byte;
	} req_t;

	// one result
	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] length_out;
		logic [7:0]  byte_out;
		logic        last_byte;
	} rsp_t;

	typedef enum logic [3:0] {
		EX_IDLE,
		EX_DECIDE,
		EX_MARK,
		EX_HDR_WR,
		EX_RD_ADDR,
		EX_RD_WAIT,
		EX_RD_DATA,
		EX_HDR_RD,
		EX_OUT
	} ex_state_t;
endpackage

// ----- sv/variable_length_message_ring_unit.sv -----
// Top level of the variable-length message ring unit.
// Stores length-prefixed messages in a RING_BYTES byte ring held in one
// single-port RAM; wraps to the start when a message does not fit before the
// end, leaving an all-ones marker where there is room for one. One request is
// carried out at a time: every access goes through the one byte-wide RAM
// port, which has a registered read. A two-entry queue in front takes
// requests while a result waits on the output register.
// No clearing pass is needed after reset.
module variable_length_message_ring_unit #(
	parameter int RING_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] op, [14:3] msg_len, [22:15] data_byte
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [13:2] length_out, [21:14] byte_out
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import vlmr_pkg::*;

	req_t in_req, q_req;
	rsp_t rsp;
	logic q_valid, q_pop;

	assign in_req.op        = s_axis_tdata[2:0];
	assign in_req.msg_len   = s_axis_tdata[14:3];
	assign in_req.data_byte = s_axis_tdata[22:15];

	vlmr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_req  (in_req),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_req   (q_req)
	);

	vlmr_exec #(.RING_BYTES(RING_BYTES)) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_req    (q_req),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_rsp  (rsp)
	);

	assign m_axis_tdata = {2'b00, rsp.byte_out, rsp.length_out, rsp.status};
	assign m_axis_tlast = rsp.last_byte;
endmodule

// ----- sv/vlmr_ram.sv -----
// Generic single-port RAM with registered read.
module vlmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- sv/vlmr_front.sv -----
// Input side: two-entry request queue between the input port and the executor.
module vlmr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  vlmr_pkg::req_t in_req,
	output logic          q_valid,
	input  logic          q_pop,
	output vlmr_pkg::req_t q_req
);
	import vlmr_pkg::*;

	req_t       buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop && q_valid) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready) else $error("queue overflow");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
`endif
endmodule

// ----- sv/vlmr_exec.sv -----
// Executor: ring state, sequencing of memory accesses, result register.
module vlmr_exec #(
	parameter int RING_BYTES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  vlmr_pkg::req_t q_req,
	output logic           out_valid,
	input  logic           out_ready,
	output vlmr_pkg::rsp_t out_rsp
);
	import vlmr_pkg::*;

	localparam int AW = $clog2(RING_BYTES);
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] RB = PW'(RING_BYTES);
	localparam logic [PW-1:0] HB = PW'(HEADER_BYTES);

	ex_state_t st_q, st_d;
	req_t      req_q;
	rsp_t      rsp_q;
	logic      out_valid_q;

	logic [PW-1:0] head_q, tail_q, wcur_q, rstart_q, rcur_q;
	logic [11:0]   rlen_q, rrem_q;
	logic          res_open_q, rd_open_q;
	logic [1:0]    bidx_q;
	logic [31:0]   word_q;
	logic [PW-1:0] hdr_base_q;
	logic          wrap_q;

	logic          mem_we;
	logic [PW-1:0] mem_a;
	logic [7:0]    mem_wd, mem_rd;

	vlmr_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
		.clk  (clk),
		.we   (mem_we && mem_a < RB),
		.addr (mem_a[AW-1:0]),
		.wdata(mem_wd),
		.rdata(mem_rd)
	);

	assign out_valid = out_valid_q;
	assign out_rsp   = rsp_q;
	assign q_pop     = (st_q == EX_IDLE) && q_valid && !out_valid_q;

	// free-space decision for reserve
	logic [PW+12:0] need_here, need_zero;
	logic           fit_here, fit_zero, h_ge_t, mark_fits;
	assign need_here = (PW+13)'(head_q) + (PW+13)'(HB) + (PW+13)'(req_q.msg_len);
	assign need_zero = (PW+13)'(HB) + (PW+13)'(req_q.msg_len);
	assign h_ge_t    = head_q >= tail_q;
	assign fit_here  = h_ge_t ? (need_here <= (PW+13)'(RB)) : (need_here < (PW+13)'(tail_q));
	assign fit_zero  = need_zero < (PW+13)'(tail_q);
	assign mark_fits = (head_q + HB) <= RB;

	always_comb begin
		mem_we = 1'b0;
		mem_a  = bidx_addr();
		mem_wd = 8'hFF;
		case (st_q)
			EX_MARK: begin
				mem_we = 1'b1;
				mem_wd = 8'hFF;
			end
			EX_HDR_WR: begin
				mem_we = 1'b1;
				mem_wd = word_q[8*bidx_q +: 8];
			end
			EX_RD_ADDR: mem_a = rcur_q;
			default: begin
				if (st_q == EX_DECIDE && req_q.op == OP_WRITE) begin
					mem_a  = wcur_q;
					mem_wd = req_q.data_byte;
					mem_we = res_open_q && (wcur_q < rstart_q + HB + PW'(rlen_q));
				end
			end
		endcase
	end

	// state after decode: memory sequences for marker, header write, header read, byte read
	always_comb begin
		st_d = EX_OUT;
		case (req_q.op)
			OP_RESERVE: begin
				if (!res_open_q && !fit_here && h_ge_t && fit_zero && mark_fits) begin
					st_d = EX_MARK;
				end
			end
			OP_COMMIT: begin
				if (res_open_q) begin
					st_d = EX_HDR_WR;
				end
			end
			OP_PEEK, OP_RELEASE: begin
				if (head_q != tail_q) begin
					st_d = EX_HDR_RD;
				end
			end
			OP_READ: begin
				if (rd_open_q && rrem_q != '0) begin
					st_d = EX_RD_ADDR;
				end
			end
			default: ;
		endcase
	end

	function automatic logic [PW-1:0] bidx_addr();
		return hdr_base_q + PW'(bidx_q);
	endfunction

	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q <= q_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= EX_IDLE;
			out_valid_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			wcur_q      <= '0;
			rstart_q    <= '0;
			rcur_q      <= '0;
			rlen_q      <= '0;
			rrem_q      <= '0;
			res_open_q  <= 1'b0;
			rd_open_q   <= 1'b0;
			bidx_q      <= '0;
			word_q      <= '0;
			hdr_base_q  <= '0;
			wrap_q      <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				EX_IDLE: begin
					if (q_pop) begin
						st_q  <= EX_DECIDE;
						rsp_q <= '{status: ST_SEQ, length_out: '0, byte_out: '0,
							last_byte: 1'b0};
					end
				end
				EX_DECIDE: begin
					st_q <= st_d;
					case (req_q.op)
						OP_RESERVE: begin
							if (!res_open_q) begin
								if (fit_here || (h_ge_t && fit_zero)) begin
									res_open_q     <= 1'b1;
									rlen_q         <= req_q.msg_len;
									rsp_q.status     <= ST_OK;
									rsp_q.length_out <= req_q.msg_len;
									if (fit_here) begin
										rstart_q <= head_q;
										wcur_q   <= head_q + HB;
									end else begin
										rstart_q <= '0;
										wcur_q   <= HB;
										if (mark_fits) begin
											hdr_base_q <= head_q;
											bidx_q     <= '0;
										end
									end
								end else begin
									rsp_q.status <= ST_NOSPC;
								end
							end
						end
						OP_WRITE: begin
							if (mem_we) begin
								wcur_q       <= wcur_q + PW'(1);
								rsp_q.status <= ST_OK;
							end
						end
						OP_COMMIT: begin
							if (res_open_q) begin
								word_q     <= {20'd0, rlen_q};
								hdr_base_q <= rstart_q;
								bidx_q     <= '0;
								head_q     <= rstart_q + HB + PW'(rlen_q);
								res_open_q <= 1'b0;
								rsp_q.status     <= ST_OK;
								rsp_q.length_out <= rlen_q;
							end
						end
						OP_PEEK, OP_RELEASE: begin
							if (head_q == tail_q) begin
								rsp_q.status <= ST_EMPTY;
							end else begin
								bidx_q <= '0;
								if (tail_q + HB > RB) begin
									hdr_base_q <= '0;
									wrap_q     <= 1'b1;
								end else begin
									hdr_base_q <= tail_q;
									wrap_q     <= 1'b0;
								end
							end
						end
						default: ;
					endcase
				end
				EX_MARK, EX_HDR_WR: begin
					bidx_q <= bidx_q + 2'd1;
					if (bidx_q == 2'd3) begin
						st_q <= EX_OUT;
					end
				end
				EX_RD_ADDR: st_q <= EX_RD_WAIT;
				EX_RD_WAIT: begin
					rsp_q.status    <= ST_OK;
					rsp_q.byte_out  <= (rcur_q < RB) ? mem_rd : 8'd0;
					rsp_q.last_byte <= (rrem_q == 12'd1);
					rcur_q <= rcur_q + PW'(1);
					rrem_q <= rrem_q - 12'd1;
					st_q   <= EX_OUT;
				end
				EX_HDR_RD: begin
					// header bytes one at a time: address in EX_HDR_RD, data in EX_RD_DATA
					st_q <= EX_RD_DATA;
				end
				EX_RD_DATA: begin
					word_q <= {mem_rd, word_q[31:8]};
					if (bidx_q == 2'd3) begin
						if (!wrap_q && {mem_rd, word_q[31:8]} == 32'hFFFF_FFFF) begin
							// explicit wrap marker: restart at 0
							wrap_q     <= 1'b1;
							hdr_base_q <= '0;
							bidx_q     <= '0;
							st_q       <= EX_HDR_RD;
						end else begin
							st_q             <= EX_OUT;
							rsp_q.status     <= ST_OK;
							rsp_q.length_out <= mem_rd_len({mem_rd, word_q[31:8]});
							if (req_q.op == OP_PEEK) begin
								rcur_q    <= hdr_base_q + HB;
								rrem_q    <= mem_rd_len({mem_rd, word_q[31:8]});
								rd_open_q <= 1'b1;
							end else begin
								tail_q    <= hdr_base_q + HB
									+ PW'(mem_rd_len({mem_rd, word_q[31:8]}));
								rd_open_q <= 1'b0;
								rrem_q    <= '0;
							end
						end
					end else begin
						bidx_q <= bidx_q + 2'd1;
						st_q   <= EX_HDR_RD;
					end
				end
				EX_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						st_q        <= EX_IDLE;
					end
				end
				default: st_q <= EX_IDLE;
			endcase
		end
	end

	function automatic logic [11:0] mem_rd_len(logic [31:0] w);
		return w[11:0];
	endfunction

`ifndef SYNTHESIS
	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> st_q == EX_IDLE) else $error("pop while busy");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q) else $error("result dropped");
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= RB && tail_q <= RB) else $error("offset out of range");
`endif
endmodule
